@@ hw/rtl/cia_pkg.sv @@
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, codes and helpers for the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned NCells = DataW;

    localparam logic [7:0] OpAdd = 8'h2B;
    localparam logic [7:0] OpSub = 8'h2D;
    localparam logic [7:0] OpMul = 8'h2A;
    localparam logic [7:0] OpDiv = 8'h2F;
    localparam logic [7:0] OpMod = 8'h25;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StOvf     = 3'd1;
    localparam logic [2:0] StUnf     = 3'd2;
    localparam logic [2:0] StDivZero = 3'd3;
    localparam logic [2:0] StUnknown = 3'd4;

    localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};

    // One transaction as it travels down the chain
    typedef struct packed {
        logic             vld;
        logic [7:0]       op;
        logic             is_mul;
        logic             is_div;     // '/' or '%'
        logic             sgn;        // operand signs differ
        logic             a_neg;
        logic [2:0]       st;
        logic [DataW-1:0] b;          // raw right operand
        logic [DataW-1:0] acc;        // product high half / remainder
        logic [DataW-1:0] q;          // product low half / quotient
        logic [DataW-1:0] m;          // multiplicand / divisor magnitude
    } t_stage;

    function automatic logic [1:0] prec_of(input logic [7:0] op);
        logic [1:0] p;
        case (op)
            OpAdd, OpSub: p = 2'd1;
            OpMod:        p = 2'd2;
            OpMul, OpDiv: p = 2'd3;
            default:      p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/checked_integer_alu.sv @@
// ----------------------------------------------------------------------------
// checked_integer_alu
// Checked 64-bit add, subtract, multiply, divide and modulo with status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries the operator character and two
//   signed 64-bit operands. Output channel o_valid/i_ready returns the
//   value, a status code and the operator precedence, one per transaction.
//   Multiply and divide run through a chain of 64 cells, one operand bit
//   per cell; every transaction passes the 64 cells and then the output
//   register on its way to o_valid. Add and subtract are resolved at
//   entry and ride the same chain, keeping order.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the chain holds up to 65 transactions in flight.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and o_ready drops; it advances again as soon as the result is taken.
//   Reset clears every valid flag in the chain and that of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_alu (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [7:0]                i_req_type,
    input  wire logic [cia_pkg::DataW-1:0] i_left_operand,
    input  wire logic [cia_pkg::DataW-1:0] i_right_operand,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [cia_pkg::DataW-1:0]      o_result_value,
    output logic [2:0]                     o_status,
    output logic [1:0]                     o_precedence
);
    import cia_pkg::*;

    t_stage           w_chain [0:NCells];
    t_stage           w_head;
    logic             w_adv;
    logic [DataW-1:0] w_mag_a;
    logic [DataW-1:0] w_mag_b;
    logic [DataW-1:0] w_s;
    logic [DataW-1:0] w_neg_r;
    logic [DataW-1:0] w_val;
    logic [2:0]       w_st;
    t_stage           w_tail;

    logic             r_out_vld;
    logic [DataW-1:0] r_val;
    logic [2:0]       r_st;
    logic [1:0]       r_prec;

    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = w_adv;

    // entry: magnitudes, add/sub and early status
    always_comb begin
        w_mag_a = i_left_operand[DataW-1] ? (~i_left_operand + 1'b1) : i_left_operand;
        w_mag_b = i_right_operand[DataW-1] ? (~i_right_operand + 1'b1) : i_right_operand;
        w_head        = '0;
        w_head.vld    = i_valid;
        w_head.op     = i_req_type;
        w_head.a_neg  = i_left_operand[DataW-1];
        w_head.sgn    = i_left_operand[DataW-1] ^ i_right_operand[DataW-1];
        w_head.b      = i_right_operand;
        case (i_req_type)
            OpAdd: begin
                w_head.acc = i_left_operand + i_right_operand;
                if (i_left_operand[DataW-1] == i_right_operand[DataW-1] &&
                    w_head.acc[DataW-1] != i_left_operand[DataW-1]) begin
                    w_head.st = i_left_operand[DataW-1] ? StUnf : StOvf;
                end
            end
            OpSub: begin
                w_head.acc = i_left_operand - i_right_operand;
                if (i_left_operand[DataW-1] != i_right_operand[DataW-1] &&
                    w_head.acc[DataW-1] != i_left_operand[DataW-1]) begin
                    w_head.st = i_left_operand[DataW-1] ? StUnf : StOvf;
                end
            end
            OpMul: begin
                w_head.is_mul = 1'b1;
                w_head.q      = w_mag_b;
                w_head.m      = w_mag_a;
            end
            OpDiv, OpMod: begin
                w_head.is_div = 1'b1;
                w_head.q      = w_mag_a;
                w_head.m      = w_mag_b;
                if (i_right_operand == '0) begin
                    w_head.st = StDivZero;
                end
            end
            default: begin
                w_head.st = StUnknown;
            end
        endcase
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < NCells; g++) begin : g_cell
        cia_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign w_tail  = w_chain[NCells];
    assign w_neg_r = ~w_tail.acc + 1'b1;
    assign w_s     = w_neg_r + w_tail.b;

    // exit: range checks and sign fix-up; an early status stands as it is
    always_comb begin
        w_val = '0;
        w_st  = w_tail.st;
        if (w_tail.st == StOk) begin
            case (w_tail.op)
                OpAdd, OpSub: begin
                    w_val = w_tail.acc;
                end
                OpMul: begin
                    if (w_tail.acc != '0) begin
                        w_st = StOvf;
                    end else if (w_tail.sgn) begin
                        if (w_tail.q > SignBit) w_st = StOvf;
                        else w_val = ~w_tail.q + 1'b1;
                    end else begin
                        if (w_tail.q >= SignBit) w_st = StOvf;
                        else w_val = w_tail.q;
                    end
                end
                OpDiv: begin
                    if (w_tail.sgn) begin
                        w_val = ~w_tail.q + 1'b1;
                    end else if (w_tail.q >= SignBit) begin
                        w_st = StOvf;
                    end else begin
                        w_val = w_tail.q;
                    end
                end
                OpMod: begin
                    if (w_tail.a_neg && w_tail.acc != '0) begin
                        w_val = w_s;
                        if (w_neg_r[DataW-1] == w_tail.b[DataW-1] &&
                            w_s[DataW-1] != w_neg_r[DataW-1]) begin
                            w_st = w_neg_r[DataW-1] ? StUnf : StOvf;
                        end
                    end else begin
                        w_val = w_tail.acc;
                    end
                end
                default: begin
                    w_val = '0;
                end
            endcase
        end
        if (w_st != StOk) begin
            w_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_tail.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_val  <= w_val;
            r_st   <= w_st;
            r_prec <= prec_of(w_tail.op);
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_value = r_val;
    assign o_status       = r_st;
    assign o_precedence   = r_prec;

endmodule

`default_nettype wire

@@ hw/rtl/cia_cell.sv @@
// ----------------------------------------------------------------------------
// cia_cell
// One bit step of shift-add multiply or restoring divide, then a register.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire cia_pkg::t_stage i_stage,
    output cia_pkg::t_stage      o_stage
);
    import cia_pkg::*;

    t_stage               n_stage;
    t_stage               r_stage;
    logic                 r_vld;
    logic [DataW:0]       w_sum;
    logic [DataW-1:0]     w_sh;
    logic [DataW:0]       w_diff;

    always_comb begin
        n_stage = i_stage;
        w_sum   = {1'b0, i_stage.acc} + {1'b0, (i_stage.q[0] ? i_stage.m : '0)};
        w_sh    = {i_stage.acc[DataW-2:0], i_stage.q[DataW-1]};
        w_diff  = {1'b0, w_sh} - {1'b0, i_stage.m};
        if (i_stage.is_mul) begin
            n_stage.acc = w_sum[DataW:1];
            n_stage.q   = {w_sum[0], i_stage.q[DataW-1:1]};
        end else if (i_stage.is_div) begin
            // keep the trial difference when it does not borrow
            n_stage.acc = w_diff[DataW] ? w_sh : w_diff[DataW-1:0];
            n_stage.q   = {i_stage.q[DataW-2:0], ~w_diff[DataW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    always_comb begin
        o_stage     = r_stage;
        o_stage.vld = r_vld;
    end

endmodule

`default_nettype wire
